FILE: hdl/tmr_pkg.sv
// Shared types and constants of the text mode pixel renderer.
`timescale 1ns / 1ps

package tmr_pkg;

  localparam int ADDR_W  = 20;
  localparam int BYTE_W  = 8;
  localparam int PX_W    = 10;
  localparam int PY_W    = 9;
  localparam int COLOR_W = 24;
  localparam int PAL_W   = 4;

  localparam logic [ADDR_W-1:0] TEXT_BASE_RESET = 20'h0B800;
  localparam logic [ADDR_W-1:0] FONT_BASE_RESET = 20'h0C800;

  // Result queue behind the pipeline; a power of two so the pointers wrap.
  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_PTR_W      = 3;
  localparam int RES_CNT_W      = 4;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_RENDER = 1'b1
  } func_e;

  typedef enum logic {
    REG_TEXT_BASE = 1'b0,
    REG_FONT_BASE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] byte_value;
    logic [PX_W-1:0]   pixel_x;
    logic [PY_W-1:0]   pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [PAL_W-1:0]   palette_index;
    logic               is_foreground;
  } result_t;

  localparam logic [COLOR_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
    24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
    24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
    24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
  };

endpackage

FILE: hdl/tmr_chan_if.sv
// Channel interfaces of the text mode pixel renderer: input items, results, register writes.
`timescale 1ns / 1ps

interface tmr_in_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  func_e             func;
  logic [ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0] byte_value;
  logic [PX_W-1:0]   pixel_x;
  logic [PY_W-1:0]   pixel_y;

  modport source (
    output valid, func, byte_address, byte_value, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, func, byte_address, byte_value, pixel_x, pixel_y,
    output ready
  );
endinterface

interface tmr_out_if;
  import tmr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [PAL_W-1:0]   palette_index;
  logic               is_foreground;

  modport source (
    output valid, pixel_color, palette_index, is_foreground,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, palette_index, is_foreground,
    output ready
  );
endinterface

interface tmr_cfg_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  cfg_reg_e          index;
  logic [ADDR_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: hdl/tmr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tmr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tmr_pipe.sv
// Four-stage write and render pipeline around the text and glyph stores.
`timescale 1ns / 1ps

module tmr_pipe #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_HEIGHT = 16,
  parameter int STORE_BYTES  = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic                      render_i,
  input  tmr_pkg::in_item_t         item_i,
  input  logic [tmr_pkg::ADDR_W-1:0] text_base_i,
  input  logic [tmr_pkg::ADDR_W-1:0] font_base_i,
  output logic                      res_valid_o,
  output tmr_pkg::result_t          res_o
);
  import tmr_pkg::*;

  localparam int IDX_W       = $clog2(STORE_BYTES);
  localparam int BANK_W      = IDX_W - 1;
  localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
  localparam int COL_W       = $clog2(TEXT_COLUMNS);
  localparam int ROW_W       = $clog2(TEXT_ROWS + 1);
  localparam int LINE_W      = $clog2(GLYPH_HEIGHT);
  // Row = floor(y / GLYPH_HEIGHT) by a rounded-up reciprocal; the error stays
  // below 1/GLYPH_HEIGHT for every 9-bit y, so the quotient is exact.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2 ** RECIP_SHIFT + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam int PROD_W      = PY_W + RECIP_W;

  // Stage 1: window offsets and the row multiplication.
  logic              s1_write_q, s1_render_q;
  in_item_t          s1_item_q;
  logic [ADDR_W-1:0] toff, foff;
  logic              t_hit, f_hit;
  logic [PROD_W-1:0] row_prod;

  // Stage 2: text store access.
  logic              s2_thit_q, s2_fhit_q, s2_render_q;
  logic [IDX_W-1:0]  s2_toff_q, s2_foff_q;
  logic [BYTE_W-1:0] s2_value_q;
  logic [COL_W-1:0]  s2_col_q;
  logic [2:0]        s2_xbit_q;
  logic [PY_W-1:0]   s2_py_q;
  logic [ROW_W-1:0]  s2_row_q;
  logic [LINE_W-1:0] line;
  logic [BANK_W-1:0] hcell;
  logic [BYTE_W-1:0] ch, attr;

  // Stage 3: glyph store access.
  logic              s3_fhit_q, s3_render_q;
  logic [IDX_W-1:0]  s3_foff_q;
  logic [BYTE_W-1:0] s3_value_q;
  logic [LINE_W-1:0] s3_line_q;
  logic [2:0]        s3_xbit_q;
  logic [IDX_W-1:0]  gaddr;

  // Stage 4: bit test and palette.
  logic              s4_render_q;
  logic [BYTE_W-1:0] s4_attr_q;
  logic [2:0]        s4_xbit_q;
  logic [BYTE_W-1:0] bits;
  logic              fg;
  logic [PAL_W-1:0]  idx;
  result_t           res_d, res_q;
  logic              res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_write_q  <= 1'b0;
      s1_render_q <= 1'b0;
      s2_thit_q   <= 1'b0;
      s2_fhit_q   <= 1'b0;
      s2_render_q <= 1'b0;
      s3_fhit_q   <= 1'b0;
      s3_render_q <= 1'b0;
      s4_render_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_write_q  <= take_i && (item_i.func == FUNC_WRITE);
      s1_render_q <= take_i && render_i;
      s2_thit_q   <= t_hit;
      s2_fhit_q   <= f_hit;
      s2_render_q <= s1_render_q;
      s3_fhit_q   <= s2_fhit_q;
      s3_render_q <= s2_render_q;
      s4_render_q <= s3_render_q;
      res_valid_q <= s4_render_q;
    end
  end

  always_comb begin
    toff     = s1_item_q.byte_address - text_base_i;
    foff     = s1_item_q.byte_address - font_base_i;
    t_hit    = s1_write_q && (toff < ADDR_W'(STORE_BYTES));
    f_hit    = s1_write_q && (foff < ADDR_W'(STORE_BYTES));
    row_prod = PROD_W'(s1_item_q.pixel_y) * PROD_W'(RECIP);
  end

  always_comb begin
    line  = LINE_W'(s2_py_q - PY_W'(s2_row_q * GLYPH_HEIGHT));
    hcell = BANK_W'(s2_col_q) + BANK_W'(s2_row_q * TEXT_COLUMNS);
    gaddr = IDX_W'(GLYPH_HEIGHT * ch) + IDX_W'(s3_line_q);
    fg    = bits[3'd7 - s4_xbit_q];
    idx   = fg ? s4_attr_q[3:0] : s4_attr_q[7:4];
    res_d.pixel_color   = PALETTE[idx];
    res_d.palette_index = idx;
    res_d.is_foreground = fg;
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_item_q <= item_i;
    end
    s2_toff_q  <= toff[IDX_W-1:0];
    s2_foff_q  <= foff[IDX_W-1:0];
    s2_value_q <= s1_item_q.byte_value;
    s2_col_q   <= COL_W'(s1_item_q.pixel_x >> 3);
    s2_xbit_q  <= s1_item_q.pixel_x[2:0];
    s2_py_q    <= s1_item_q.pixel_y;
    s2_row_q   <= row_prod[RECIP_SHIFT +: ROW_W];
    s3_foff_q  <= s2_foff_q;
    s3_value_q <= s2_value_q;
    s3_line_q  <= line;
    s3_xbit_q  <= s2_xbit_q;
    s4_attr_q  <= attr;
    s4_xbit_q  <= s3_xbit_q;
    res_q      <= res_d;
  end

  // Character bytes sit at even text offsets, attributes at odd ones.
  tmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_text_even (
    .clk_i   (clk_i),
    .we_i    (s2_thit_q && !s2_toff_q[0]),
    .waddr_i (s2_toff_q[IDX_W-1:1]),
    .wdata_i (s2_value_q),
    .raddr_i (hcell),
    .rdata_o (ch)
  );

  tmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_text_odd (
    .clk_i   (clk_i),
    .we_i    (s2_thit_q && s2_toff_q[0]),
    .waddr_i (s2_toff_q[IDX_W-1:1]),
    .wdata_i (s2_value_q),
    .raddr_i (hcell),
    .rdata_o (attr)
  );

  tmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_glyph (
    .clk_i   (clk_i),
    .we_i    (s3_fhit_q),
    .waddr_i (s3_foff_q),
    .wdata_i (s3_value_q),
    .raddr_i (gaddr),
    .rdata_o (bits)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/tmr_res_fifo.sv
// Result queue between the render pipeline and the output channel.
`timescale 1ns / 1ps

module tmr_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tmr_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output tmr_pkg::result_t data_o
);
  import tmr_pkg::*;

  result_t              buf_q [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + RES_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

endmodule

FILE: hdl/text_mode_pixel_renderer_top.sv
// Top level of the text mode pixel renderer: ports, window registers, result credits.
`timescale 1ns / 1ps

// Channel      Port        Dir   Transaction carries
// items        in_chan_i   sink  func, byte_address, byte_value, pixel_x, pixel_y
// results      res_chan_o  src   pixel_color, palette_index, is_foreground
// registers    cfg_chan_i  sink  index (text or font window base), data
//
// One item is taken every cycle for as long as the output side keeps pace.
// A rendered pixel passes in order through offset and row multiply, text store
// read, glyph store read, bit test and palette, and the output register, then
// waits in the result queue. The two dependent store reads set the pipeline depth.
// Reset clears the window bases to their defaults; the stores are not cleared.
// Input ready falls once eight results are owed and returns as results leave.

module text_mode_pixel_renderer_top #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_HEIGHT = 16,
  parameter int STORE_BYTES  = 4096
) (
  input logic      clk_i,
  input logic      rst_ni,
  tmr_in_if.sink   in_chan_i,
  tmr_out_if.source res_chan_o,
  tmr_cfg_if.sink  cfg_chan_i
);
  import tmr_pkg::*;

  logic [ADDR_W-1:0]    text_base_q, font_base_q;
  logic [RES_CNT_W-1:0] owed_q, owed_d;
  logic                 in_take, out_take, on_screen, render;
  in_item_t             item;
  logic                 pipe_valid;
  result_t              pipe_res, fifo_res;
  logic                 fifo_valid;

  // Window base registers. Software writes them only while the block is idle
  // (the block itself does not enforce this), so every stage may read them directly.
  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= TEXT_BASE_RESET;
      font_base_q <= FONT_BASE_RESET;
    end else if (cfg_chan_i.valid) begin
      unique case (cfg_chan_i.index)
        REG_TEXT_BASE: text_base_q <= cfg_chan_i.data;
        REG_FONT_BASE: font_base_q <= cfg_chan_i.data;
        default:       text_base_q <= text_base_q;
      endcase
    end
  end

  // A render whose pixel falls outside the screen gives no result, so only
  // on-screen renders take a credit from the result queue.
  always_comb begin
    item.func         = in_chan_i.func;
    item.byte_address = in_chan_i.byte_address;
    item.byte_value   = in_chan_i.byte_value;
    item.pixel_x      = in_chan_i.pixel_x;
    item.pixel_y      = in_chan_i.pixel_y;
    on_screen = (in_chan_i.pixel_x < PX_W'(8 * TEXT_COLUMNS)) &&
                (in_chan_i.pixel_y < PY_W'(GLYPH_HEIGHT * TEXT_ROWS));
    render    = (in_chan_i.func == FUNC_RENDER) && on_screen;
  end

  // Every result owed sits either in the pipeline or in the queue, so holding
  // the count at or below the queue depth means the queue can never overflow and
  // the pipeline never has to stall.
  assign in_chan_i.ready = (owed_q != RES_CNT_W'(RES_FIFO_DEPTH));
  assign in_take         = in_chan_i.valid && in_chan_i.ready;
  assign out_take        = res_chan_o.valid && res_chan_o.ready;

  always_comb begin
    owed_d = owed_q;
    if ((in_take && render) && !out_take) begin
      owed_d = owed_q + RES_CNT_W'(1);
    end else if (out_take && !(in_take && render)) begin
      owed_d = owed_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_d;
    end
  end

  // Writes and reads of each store happen at one fixed stage, so accesses to
  // a store keep transaction order and no forwarding is required.
  tmr_pipe #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .STORE_BYTES  (STORE_BYTES)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_take),
    .render_i    (render),
    .item_i      (item),
    .text_base_i (text_base_q),
    .font_base_i (font_base_q),
    .res_valid_o (pipe_valid),
    .res_o       (pipe_res)
  );

  tmr_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pipe_valid),
    .push_data_i (pipe_res),
    .pop_i       (out_take),
    .valid_o     (fifo_valid),
    .data_o      (fifo_res)
  );

  assign res_chan_o.valid         = fifo_valid;
  assign res_chan_o.pixel_color   = fifo_res.pixel_color;
  assign res_chan_o.palette_index = fifo_res.palette_index;
  assign res_chan_o.is_foreground = fifo_res.is_foreground;

endmodule
